/* src/frame_interval_statistics_defines.svh */
// assertion macros for the frame interval statistics block
// used by the top level; expects clk and rst_n in scope
`ifndef FRAME_INTERVAL_STATISTICS_DEFINES_SVH
`define FRAME_INTERVAL_STATISTICS_DEFINES_SVH

// same-cycle implication, checked out of reset
`define FIS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("fis assertion failed");

// next-cycle implication, checked out of reset
`define FIS_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("fis assertion failed");

`endif

/* src/fis_pkg.sv */
// shared widths, register codes and control structs for frame interval statistics
// no dependencies; imported by every file except the defines header
`default_nettype none

package fis_pkg;

  // field and state widths
  localparam int TIME_WIDTH  = 32;
  localparam int COUNT_WIDTH = 24;
  localparam int TOTAL_WIDTH = 48;
  localparam int SCALE_WIDTH = 16;
  localparam int FRAC_BITS   = 8;
  localparam int PROD_WIDTH  = TIME_WIDTH + SCALE_WIDTH;
  localparam int SUM_WIDTH   = TIME_WIDTH + 2;
  localparam int DIV_CNT_WIDTH = $clog2(SUM_WIDTH + 1);

  // configuration port
  localparam int CFG_INDEX_WIDTH = 2;
  localparam int CFG_DATA_WIDTH  = 32;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_TIME_SCALE    = 2'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_DISCARD_LIMIT = 2'd1;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_WINDOW_LENGTH = 2'd2;

  // register reset values
  localparam logic [SCALE_WIDTH-1:0] TIME_SCALE_RST    = 16'd256;
  localparam logic [TIME_WIDTH-1:0]  DISCARD_LIMIT_RST = 32'd200000;
  localparam logic [TIME_WIDTH-1:0]  WINDOW_LENGTH_RST = 32'd1000000;

  // controller to datapath commands
  typedef struct packed {
    logic load;
    logic mul;
    logic eval;
    logic div_start;
    logic publish;
    logic out_load;
  } fis_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic close;
    logic div_done;
    logic out_free;
  } fis_sts_t;

endpackage

`default_nettype wire

/* src/fis_ifs.sv */
// valid/ready channel interfaces: input item, result item, configuration write
// depends on fis_pkg
`default_nettype none

interface fis_in_if import fis_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [TIME_WIDTH-1:0] frame_interval;

  modport source (output valid, output frame_interval, input ready);
  modport sink   (input valid, input frame_interval, output ready);
endinterface

interface fis_out_if import fis_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [TIME_WIDTH-1:0]  elapsed;
  logic                   discarded;
  logic [TOTAL_WIDTH-1:0] total_time;
  logic                   window_closed;
  logic [COUNT_WIDTH-1:0] frames_in_window;
  logic [TIME_WIDTH-1:0]  average_interval;
  logic [TIME_WIDTH-1:0]  min_interval;
  logic [TIME_WIDTH-1:0]  max_interval;

  modport source (output valid, output elapsed, output discarded, output total_time,
                  output window_closed, output frames_in_window, output average_interval,
                  output min_interval, output max_interval, input ready);
  modport sink   (input valid, input elapsed, input discarded, input total_time,
                  input window_closed, input frames_in_window, input average_interval,
                  input min_interval, input max_interval, output ready);
endinterface

interface fis_cfg_if import fis_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic [CFG_INDEX_WIDTH-1:0] index;
  logic [CFG_DATA_WIDTH-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

/* src/frame_interval_statistics.sv */
// Frame interval statistics, top level.
// Channels: in_ch takes one frame event (frame_interval, raw microsecond
// ticks); out_ch returns one result item per event; cfg_ch writes
// time_scale (index 0), discard_limit (1) and window_length (2), always ready.
// Each event is scaled by the Q8.8 time scale, checked against the discard
// limit and folded into the window statistics. A window that closes
// publishes frame count, average, minimum and maximum.
// Ordinary events pass through the multiply, evaluate and branch steps to the
// output register; an event that closes a window also waits for the 34-step
// bit-serial divider that forms the average. One event is in flight at a time,
// so a new event is accepted only once the last result is loaded.
// A result waits in an output register; the next event is accepted while it
// waits, and the block holds in its final step only if a second result is
// ready before the first is taken.
// Reset (rst_n low, synchronous) restores the register defaults and clears
// all statistics; published fields read zero until a window closes.
// depends on fis_pkg, fis_ifs, fis_ctrl, fis_datapath and the defines header
`default_nettype none
`include "frame_interval_statistics_defines.svh"

module frame_interval_statistics import fis_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  fis_in_if.sink     in_ch,
  fis_out_if.source  out_ch,
  fis_cfg_if.sink    cfg_ch
);

  fis_cmd_t cmd;
  fis_sts_t sts;

  // configuration is always taken
  assign cfg_ch.ready = 1'b1;

  // sequencing
  fis_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // arithmetic and state
  fis_datapath u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cmd                  (cmd),
    .sts                  (sts),
    .in_frame_interval    (in_ch.frame_interval),
    .cfg_we               (cfg_ch.valid && cfg_ch.ready),
    .cfg_index            (cfg_ch.index),
    .cfg_data             (cfg_ch.data),
    .out_ready            (out_ch.ready),
    .out_valid            (out_ch.valid),
    .out_elapsed          (out_ch.elapsed),
    .out_discarded        (out_ch.discarded),
    .out_total_time       (out_ch.total_time),
    .out_window_closed    (out_ch.window_closed),
    .out_frames_in_window (out_ch.frames_in_window),
    .out_average_interval (out_ch.average_interval),
    .out_min_interval     (out_ch.min_interval),
    .out_max_interval     (out_ch.max_interval)
  );

  // a discarded event never closes a window
  `FIS_ASSERT_IMP(a_closed_not_disc, out_ch.valid && out_ch.window_closed, !out_ch.discarded)
  // one event in flight: no accept right after an accept
  `FIS_ASSERT_NXT(a_one_in_flight, in_ch.valid && in_ch.ready, !in_ch.ready)
  // a result is loaded only when the output register can take it
  `FIS_ASSERT_IMP(a_out_load_free, cmd.out_load, sts.out_free)
  // no new event is taken and no result is loaded right after the divider starts
  `FIS_ASSERT_NXT(a_div_busy, cmd.div_start, !in_ch.ready && !cmd.out_load)

endmodule

`default_nettype wire

/* src/fis_div.sv */
// radix-2 restoring divider, one quotient bit per cycle
// depends on fis_pkg
`default_nettype none

module fis_div import fis_pkg::*; (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   start,
  input  wire logic [SUM_WIDTH-1:0]   dividend,
  input  wire logic [COUNT_WIDTH-1:0] divisor,
  output logic                        done,
  output logic [SUM_WIDTH-1:0]        quotient
);

  logic                     busy_r;
  logic                     done_r;
  logic [DIV_CNT_WIDTH-1:0] cnt_r;
  logic [SUM_WIDTH-1:0]     quo_r;
  logic [COUNT_WIDTH-1:0]   rem_r;
  logic [COUNT_WIDTH-1:0]   den_r;

  logic [COUNT_WIDTH:0]     rem_sh;
  logic [COUNT_WIDTH:0]     rem_diff;
  logic                     q_bit;
  logic [COUNT_WIDTH-1:0]   rem_nxt;

  // shift in next dividend bit, trial subtract
  always_comb begin
    rem_sh   = {rem_r, quo_r[SUM_WIDTH-1]};
    rem_diff = rem_sh - {1'b0, den_r};
    q_bit    = (rem_sh >= {1'b0, den_r});
    rem_nxt  = q_bit ? rem_diff[COUNT_WIDTH-1:0] : rem_sh[COUNT_WIDTH-1:0];
  end

  // iteration control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= DIV_CNT_WIDTH'(SUM_WIDTH);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == DIV_CNT_WIDTH'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // operand and partial result registers
  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      den_r <= divisor;
    end else if (busy_r) begin
      quo_r <= {quo_r[SUM_WIDTH-2:0], q_bit};
      rem_r <= rem_nxt;
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

`default_nettype wire

/* src/fis_ctrl.sv */
// sequencing state machine: accept, multiply, evaluate, divide, publish, emit
// depends on fis_pkg
`default_nettype none

module fis_ctrl import fis_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire fis_sts_t sts,
  output fis_cmd_t      cmd
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_MUL    = 3'd1;
  localparam logic [2:0] ST_EVAL   = 3'd2;
  localparam logic [2:0] ST_BRANCH = 3'd3;
  localparam logic [2:0] ST_DIV    = 3'd4;
  localparam logic [2:0] ST_PUB    = 3'd5;
  localparam logic [2:0] ST_FIN    = 3'd6;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = ST_EVAL;
      end
      ST_EVAL: begin
        cmd.eval  = 1'b1;
        state_nxt = ST_BRANCH;
      end
      ST_BRANCH: begin
        if (sts.close) begin
          cmd.div_start = 1'b1;
          state_nxt     = ST_DIV;
        end else begin
          state_nxt = ST_FIN;
        end
      end
      ST_DIV: begin
        if (sts.div_done) state_nxt = ST_PUB;
      end
      ST_PUB: begin
        cmd.publish = 1'b1;
        state_nxt   = ST_FIN;
      end
      ST_FIN: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else        state_r <= state_nxt;
  end

endmodule

`default_nettype wire

/* src/fis_datapath.sv */
// config registers, scaling multiplier, window statistics, divider, output register
// depends on fis_pkg and fis_div
`default_nettype none

module fis_datapath import fis_pkg::*; (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire fis_cmd_t                   cmd,
  output fis_sts_t                        sts,
  input  wire logic [TIME_WIDTH-1:0]      in_frame_interval,
  input  wire logic                       cfg_we,
  input  wire logic [CFG_INDEX_WIDTH-1:0] cfg_index,
  input  wire logic [CFG_DATA_WIDTH-1:0]  cfg_data,
  input  wire logic                       out_ready,
  output logic                            out_valid,
  output logic [TIME_WIDTH-1:0]           out_elapsed,
  output logic                            out_discarded,
  output logic [TOTAL_WIDTH-1:0]          out_total_time,
  output logic                            out_window_closed,
  output logic [COUNT_WIDTH-1:0]          out_frames_in_window,
  output logic [TIME_WIDTH-1:0]           out_average_interval,
  output logic [TIME_WIDTH-1:0]           out_min_interval,
  output logic [TIME_WIDTH-1:0]           out_max_interval
);

  // configuration
  logic [SCALE_WIDTH-1:0] scale_r;
  logic [TIME_WIDTH-1:0]  discard_r;
  logic [TIME_WIDTH-1:0]  wlen_r;

  // item pipeline
  logic [TIME_WIDTH-1:0]  interval_r;
  logic [PROD_WIDTH-1:0]  prod_r;
  logic                   disc_r;
  logic                   close_r;

  // statistics state
  logic [TIME_WIDTH-1:0]  last_r;
  logic [TOTAL_WIDTH-1:0] total_r;
  logic [SUM_WIDTH-1:0]   sum_r;
  logic [COUNT_WIDTH-1:0] frames_r;
  logic [TIME_WIDTH-1:0]  min_r;
  logic [TIME_WIDTH-1:0]  max_r;
  logic [COUNT_WIDTH-1:0] shown_frames_r;
  logic [TIME_WIDTH-1:0]  shown_avg_r;
  logic [TIME_WIDTH-1:0]  shown_min_r;
  logic [TIME_WIDTH-1:0]  shown_max_r;

  // output register
  logic                   out_valid_r;
  logic [TIME_WIDTH-1:0]  o_elapsed_r;
  logic                   o_disc_r;
  logic [TOTAL_WIDTH-1:0] o_total_r;
  logic                   o_closed_r;
  logic [COUNT_WIDTH-1:0] o_frames_r;
  logic [TIME_WIDTH-1:0]  o_avg_r;
  logic [TIME_WIDTH-1:0]  o_min_r;
  logic [TIME_WIDTH-1:0]  o_max_r;

  // combinational evaluation
  logic [PROD_WIDTH-FRAC_BITS-1:0] scaled_raw;
  logic [TIME_WIDTH-1:0]           scaled;
  logic                            disc;
  logic [SUM_WIDTH-1:0]            sum_nxt;
  logic [COUNT_WIDTH-1:0]          frames_nxt;
  logic                            div_done;
  logic [SUM_WIDTH-1:0]            quotient;
  logic [TIME_WIDTH-1:0]           avg_sat;

  // drop fraction, saturate, compare against the discard limit
  always_comb begin
    scaled_raw = prod_r[PROD_WIDTH-1:FRAC_BITS];
    scaled     = (|scaled_raw[PROD_WIDTH-FRAC_BITS-1:TIME_WIDTH]) ? '1
                                                                   : scaled_raw[TIME_WIDTH-1:0];
    disc       = (scaled >= discard_r);
    sum_nxt    = sum_r + {{(SUM_WIDTH-TIME_WIDTH){1'b0}}, scaled};
    frames_nxt = (&frames_r) ? frames_r : frames_r + 1'b1;
    avg_sat    = (|quotient[SUM_WIDTH-1:TIME_WIDTH]) ? '1 : quotient[TIME_WIDTH-1:0];
  end

  // configuration writes, unknown index ignored
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_r   <= TIME_SCALE_RST;
      discard_r <= DISCARD_LIMIT_RST;
      wlen_r    <= WINDOW_LENGTH_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_TIME_SCALE:    scale_r   <= cfg_data[SCALE_WIDTH-1:0];
        CFG_DISCARD_LIMIT: discard_r <= cfg_data[TIME_WIDTH-1:0];
        CFG_WINDOW_LENGTH: wlen_r    <= cfg_data[TIME_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  // capture item and scale it
  always_ff @(posedge clk) begin
    if (cmd.load) interval_r <= in_frame_interval;
    if (cmd.mul)  prod_r     <= PROD_WIDTH'(interval_r) * PROD_WIDTH'(scale_r);
  end

  // window and running statistics
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_r         <= '0;
      total_r        <= '0;
      sum_r          <= '0;
      frames_r       <= '0;
      min_r          <= '1;
      max_r          <= '0;
      shown_frames_r <= '0;
      shown_avg_r    <= '0;
      shown_min_r    <= '0;
      shown_max_r    <= '0;
      disc_r         <= 1'b0;
      close_r        <= 1'b0;
    end else if (cmd.eval) begin
      frames_r <= frames_nxt;
      disc_r   <= disc;
      close_r  <= !disc && (sum_nxt > {{(SUM_WIDTH-TIME_WIDTH){1'b0}}, wlen_r});
      if (!disc) begin
        last_r  <= scaled;
        total_r <= total_r + {{(TOTAL_WIDTH-TIME_WIDTH){1'b0}}, scaled};
        sum_r   <= sum_nxt;
        if (scaled < min_r) min_r <= scaled;
        if (scaled > max_r) max_r <= scaled;
      end
    end else if (cmd.publish) begin
      shown_frames_r <= frames_r;
      shown_avg_r    <= avg_sat;
      shown_min_r    <= min_r;
      shown_max_r    <= max_r;
      sum_r          <= '0;
      frames_r       <= '0;
      min_r          <= '1;
      max_r          <= '0;
    end
  end

  // window average
  fis_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (sum_r),
    .divisor  (frames_r),
    .done     (div_done),
    .quotient (quotient)
  );

  // result register, holds until taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      o_elapsed_r <= last_r;
      o_disc_r    <= disc_r;
      o_total_r   <= total_r;
      o_closed_r  <= close_r;
      o_frames_r  <= shown_frames_r;
      o_avg_r     <= shown_avg_r;
      o_min_r     <= shown_min_r;
      o_max_r     <= shown_max_r;
    end
  end

  assign sts.close    = close_r;
  assign sts.div_done = div_done;
  assign sts.out_free = !out_valid_r || out_ready;

  assign out_valid            = out_valid_r;
  assign out_elapsed          = o_elapsed_r;
  assign out_discarded        = o_disc_r;
  assign out_total_time       = o_total_r;
  assign out_window_closed    = o_closed_r;
  assign out_frames_in_window = o_frames_r;
  assign out_average_interval = o_avg_r;
  assign out_min_interval     = o_min_r;
  assign out_max_interval     = o_max_r;

endmodule

`default_nettype wire
